// ----- design/assert_macros.svh -----
// Assertion macros for the RTL of the sprite collision engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/stce_pkg.sv -----
// ----------------------------------------------------------------------------
// stce_pkg
// Types and constants shared by the sprite table collision engine.
// ----------------------------------------------------------------------------
`default_nettype none

package stce_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int CNT_W       = 7;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_DETECT = 2'd1;
    localparam logic [1:0] CMD_MOVE   = 2'd2;
    localparam logic [1:0] CMD_REPACK = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_HIT   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] f;
        logic [2:0] d;
    } sprite_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_RD_I,
        S_LD_I,
        S_RD_J,
        S_CMP,
        S_MV_RD,
        S_MV_WR,
        S_PK_RD,
        S_PK_WR,
        S_DONE
    } state_t;

    // Overlap test result from the compare unit.
    typedef struct packed {
        logic hit;
    } cmp_t;

endpackage

`default_nettype wire

// ----- design/stce_overlap.sv -----
// ----------------------------------------------------------------------------
// stce_overlap
// Shared box compare unit: checks two collidable sprites for overlap.
// ----------------------------------------------------------------------------
`default_nettype none

module stce_overlap (
    input  wire stce_pkg::sprite_t a,
    input  wire stce_pkg::sprite_t b,
    output stce_pkg::cmp_t         res
);
    import stce_pkg::*;

    logic [8:0] xa_w;
    logic [8:0] xb_w;
    logic [8:0] ya_h;
    logic [8:0] yb_h;

    always_comb
    begin
        xa_w = {1'b0, a.x} + {7'd0, a.f[5:4]};
        xb_w = {1'b0, b.x} + {7'd0, b.f[5:4]};
        ya_h = {1'b0, a.y} + {7'd0, a.f[7:6]};
        yb_h = {1'b0, b.y} + {7'd0, b.f[7:6]};
        res.hit = a.f[0] && b.f[0]
                && !(xa_w < {1'b0, b.x}) && !(xb_w < {1'b0, a.x})
                && !(ya_h < {1'b0, b.y}) && !(yb_h < {1'b0, a.y});
    end

endmodule

`default_nettype wire

// ----- design/sprite_table_collision_engine.sv -----
// ----------------------------------------------------------------------------
// sprite_table_collision_engine
// Sprite table with pair collision scan, movement step and repack.
// ----------------------------------------------------------------------------
// One command is taken at a time; ready is low until its result transfers.
// The 64-entry table is a single-port memory with registered read, so
// table accesses are made one at a time: move and repack read each entry
// in count and may write it back, and a collision scan reads each outer
// index once and then each partner entry of its visited pairs. After reset
// the block clears the table before accepting its first command;
// configuration writes are taken meanwhile.
`default_nettype none

module sprite_table_collision_engine (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        cfg_we,
    input  wire [6:0]  cfg_wdata,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire [1:0]  cmd,
    input  wire [5:0]  index,
    input  wire [6:0]  count,
    input  wire [7:0]  sprite_x,
    input  wire [7:0]  sprite_y,
    input  wire [7:0]  sprite_bits,
    input  wire [2:0]  direction,
    output logic       out_valid,
    input  wire        out_ready,
    output logic [1:0] status,
    output logic [5:0] first_index,
    output logic [5:0] second_index,
    output logic [6:0] packed_count
);
    import stce_pkg::*;
    `include "assert_macros.svh"

    // Table memory, one port, registered read.
    sprite_t mem [TABLE_DEPTH];
    sprite_t rd_data;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    sprite_t           mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_data <= mem[mem_addr];
    end

    state_t state_reg, state_next;
    logic [6:0] limit_reg;
    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next, wr_reg, wr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next, lim_reg, lim_next;
    logic [1:0] cmd_reg, cmd_next;
    sprite_t a_reg, a_next;
    logic [1:0] st_reg, st_next;
    logic [5:0] fi_reg, fi_next, se_reg, se_next;
    logic [6:0] pk_reg, pk_next;
    logic [6:0] eff_limit;
    cmp_t cmp;
    sprite_t moved;
    logic accept;

    stce_overlap u_cmp (.a(a_reg), .b(rd_data), .res(cmp));

    assign eff_limit = (limit_reg < 7'(TABLE_DEPTH)) ? limit_reg : 7'(TABLE_DEPTH);
    assign accept    = in_valid && in_ready;

    // Move one step in the stored direction with 8-bit wrap.
    always_comb
    begin
        moved = rd_data;
        case (rd_data.d)
            3'd0:    moved.y = rd_data.y - 8'd1;
            3'd1:    begin moved.x = rd_data.x + 8'd1; moved.y = rd_data.y - 8'd1; end
            3'd2:    moved.x = rd_data.x + 8'd1;
            3'd3:    begin moved.x = rd_data.x + 8'd1; moved.y = rd_data.y + 8'd1; end
            3'd4:    moved.y = rd_data.y + 8'd1;
            3'd5:    begin moved.x = rd_data.x - 8'd1; moved.y = rd_data.y + 8'd1; end
            3'd6:    moved.x = rd_data.x - 8'd1;
            default: begin moved.x = rd_data.x - 8'd1; moved.y = rd_data.y - 8'd1; end
        endcase
    end

    // Next state and datapath.
    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg; j_next = j_reg; wr_next = wr_reg;
        cnt_next = cnt_reg; lim_next = lim_reg; cmd_next = cmd_reg;
        a_next = a_reg; st_next = st_reg; fi_next = fi_reg;
        se_next = se_reg; pk_next = pk_reg;
        case (state_reg)
            S_CLEAR:
            begin
                i_next = i_reg + 7'd1;
                if (i_reg == 7'(TABLE_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = cmd; st_next = ST_OK; fi_next = '0;
                    se_next = '0; pk_next = '0;
                    lim_next = eff_limit; cnt_next = count;
                    state_next = S_DONE;
                    case (cmd)
                        CMD_WRITE: ;
                        CMD_DETECT:
                        begin
                            if ({1'b0, index} >= eff_limit)
                                st_next = ST_RANGE;
                            else
                            begin
                                i_next = {1'b0, index};
                                state_next = S_RD_I;
                            end
                        end
                        CMD_MOVE:
                        begin
                            i_next = '0;
                            if (count > eff_limit)
                                st_next = ST_RANGE;
                            else
                                state_next = S_MV_RD;
                        end
                        default:
                        begin
                            i_next = 7'd1; wr_next = 7'd1;
                            if (count > eff_limit)
                                st_next = ST_RANGE;
                            else if (count == 7'd0)
                                pk_next = '0;
                            else
                                state_next = S_PK_RD;
                        end
                    endcase
                end
            end
            S_RD_I:
            begin
                if (i_reg + 7'd1 >= lim_reg)
                    state_next = S_DONE;
                else
                    state_next = S_LD_I;
            end
            S_LD_I:
            begin
                a_next = rd_data;
                j_next = i_reg + 7'd1;
                if (rd_data.f[0])
                    state_next = S_RD_J;
                else
                begin
                    i_next = i_reg + 7'd1;
                    state_next = S_RD_I;
                end
            end
            S_RD_J:
                state_next = S_CMP;
            S_CMP:
            begin
                if (cmp.hit)
                begin
                    st_next = ST_HIT;
                    fi_next = i_reg[ADDR_W-1:0];
                    se_next = j_reg[ADDR_W-1:0];
                    state_next = S_DONE;
                end
                else if (j_reg + 7'd1 >= lim_reg)
                begin
                    i_next = i_reg + 7'd1;
                    state_next = S_RD_I;
                end
                else
                begin
                    j_next = j_reg + 7'd1;
                    state_next = S_RD_J;
                end
            end
            S_MV_RD:
            begin
                if (i_reg >= cnt_reg)
                    state_next = S_DONE;
                else
                    state_next = S_MV_WR;
            end
            S_MV_WR:
            begin
                i_next = i_reg + 7'd1;
                state_next = S_MV_RD;
            end
            S_PK_RD:
            begin
                if (i_reg >= cnt_reg)
                begin
                    pk_next = wr_reg;
                    state_next = S_DONE;
                end
                else
                    state_next = S_PK_WR;
            end
            S_PK_WR:
            begin
                i_next = i_reg + 7'd1;
                if (rd_data.f[2])
                    wr_next = wr_reg + 7'd1;
                state_next = S_PK_RD;
            end
            S_DONE:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Outputs and memory port.
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        out_valid = (state_reg == S_DONE);
        mem_we    = 1'b0;
        mem_addr  = i_reg[ADDR_W-1:0];
        mem_wdata = rd_data;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wdata = '0;
            end
            S_IDLE:
            begin
                mem_addr  = index;
                mem_wdata = '{x: sprite_x, y: sprite_y, f: sprite_bits, d: direction};
                mem_we    = in_valid && (cmd == CMD_WRITE);
            end
            S_RD_J, S_CMP:
                mem_addr = j_reg[ADDR_W-1:0];
            S_MV_WR:
            begin
                mem_wdata = moved;
                mem_we    = (rd_data.f[3:2] == 2'b11);
            end
            S_PK_WR:
            begin
                mem_addr = wr_reg[ADDR_W-1:0];
                mem_we   = rd_data.f[2];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            limit_reg <= 7'd64;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            if (cfg_we)
                limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg <= j_next; wr_reg <= wr_next; cnt_reg <= cnt_next;
        lim_reg <= lim_next; cmd_reg <= cmd_next; a_reg <= a_next;
        st_reg <= st_next; fi_reg <= fi_next; se_reg <= se_next; pk_reg <= pk_next;
    end

    assign status       = st_reg;
    assign first_index  = fi_reg;
    assign second_index = se_reg;
    assign packed_count = pk_reg;

    `ASSERT_IMPLY(a_hit_order, clk, rst_n, out_valid && status == ST_HIT, first_index < second_index)
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, !in_ready)
    `ASSERT_IMPLY(a_pack_bound, clk, rst_n, out_valid && cmd_reg == CMD_REPACK, packed_count <= cnt_reg)
endmodule

`default_nettype wire

// ----- dv/sprite_table_collision_engine_tb.sv -----
// ----------------------------------------------------------------------------
// sprite_table_collision_engine_tb
// Self-checking bench: a sprite table model predicts status, pair indexes and
// packed count for write, collision scan, move and repack commands under
// random input gaps, output stalls and several active sprite limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sprite_table_collision_engine_tb;
    import stce_pkg::*;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] index;
        logic [6:0] count;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] bits;
        logic [2:0] dir;
    } command_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] first;
        logic [5:0] second;
        logic [6:0] packed_cnt;
    } reply_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [6:0] cfg_wdata;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] cmd;
    logic [5:0] index;
    logic [6:0] count;
    logic [7:0] sprite_x;
    logic [7:0] sprite_y;
    logic [7:0] sprite_bits;
    logic [2:0] direction;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] status;
    logic [5:0] first_index;
    logic [5:0] second_index;
    logic [6:0] packed_count;

    // Transfer seen at the last rising edge; held until the driver reacts.
    logic       in_ready_q;

    sprite_table_collision_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .index        (index),
        .count        (count),
        .sprite_x     (sprite_x),
        .sprite_y     (sprite_y),
        .sprite_bits  (sprite_bits),
        .direction    (direction),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .first_index  (first_index),
        .second_index (second_index),
        .packed_count (packed_count)
    );

    // Shadow copy of the sprite table and the active limit register.
    sprite_t    shadow_table [TABLE_DEPTH];
    logic [6:0] shadow_active;

    command_t pending_cmds [$];
    reply_t   expected_replies [$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  hold_cycles;
    int  errors;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Overlap test with 9-bit sums so the right edge never wraps.
    function automatic bit boxes_touch(sprite_t a, sprite_t b);
        logic [8:0] xa_r, xb_r, ya_b, yb_b;
        xa_r = {1'b0, a.x} + a.f[5:4];
        xb_r = {1'b0, b.x} + b.f[5:4];
        ya_b = {1'b0, a.y} + a.f[7:6];
        yb_b = {1'b0, b.y} + b.f[7:6];
        return !(xa_r < b.x || xb_r < a.x || ya_b < b.y || yb_b < a.y);
    endfunction

    // Apply one command to the shadow table and return its reply.
    function automatic reply_t run_command(command_t c);
        reply_t r;
        int     lim;
        int     wr;
        bit     found;
        r     = '0;
        lim   = (shadow_active < TABLE_DEPTH) ? shadow_active : TABLE_DEPTH;
        found = 1'b0;
        case (c.cmd)
            CMD_WRITE:
            begin
                shadow_table[c.index] = '{x: c.x, y: c.y, f: c.bits, d: c.dir};
            end
            CMD_DETECT:
            begin
                if (c.index >= lim)
                    r.status = ST_RANGE;
                else
                    for (int i = c.index; !found && i + 1 < lim; i++)
                    begin
                        if (!shadow_table[i].f[0])
                            continue;
                        for (int j = i + 1; j < lim && !found; j++)
                            if (shadow_table[j].f[0]
                                && boxes_touch(shadow_table[i], shadow_table[j]))
                            begin
                                found    = 1'b1;
                                r.status = ST_HIT;
                                r.first  = 6'(i);
                                r.second = 6'(j);
                            end
                    end
            end
            default:
            begin
                if (c.count > lim)
                    r.status = ST_RANGE;
                else if (c.cmd == CMD_MOVE)
                begin
                    for (int i = 0; i < c.count; i++)
                    begin
                        if (shadow_table[i].f[3:2] != 2'b11)
                            continue;
                        case (shadow_table[i].d)
                            3'd0: shadow_table[i].y -= 8'd1;
                            3'd1:
                            begin
                                shadow_table[i].x += 8'd1;
                                shadow_table[i].y -= 8'd1;
                            end
                            3'd2: shadow_table[i].x += 8'd1;
                            3'd3:
                            begin
                                shadow_table[i].x += 8'd1;
                                shadow_table[i].y += 8'd1;
                            end
                            3'd4: shadow_table[i].y += 8'd1;
                            3'd5:
                            begin
                                shadow_table[i].x -= 8'd1;
                                shadow_table[i].y += 8'd1;
                            end
                            3'd6: shadow_table[i].x -= 8'd1;
                            default:
                            begin
                                shadow_table[i].x -= 8'd1;
                                shadow_table[i].y -= 8'd1;
                            end
                        endcase
                    end
                end
                else if (c.count != 0)
                begin
                    // Keep entry 0; slide alive entries down in order.
                    wr = 1;
                    for (int i = 1; i < c.count; i++)
                        if (shadow_table[i].f[2])
                        begin
                            shadow_table[wr] = shadow_table[i];
                            wr++;
                        end
                    r.packed_cnt = 7'(wr);
                end
            end
        endcase
        return r;
    endfunction

    function automatic command_t make_cmd(logic [1:0] op, int idx, int cnt, int px,
                                          int py, int fl, int dr);
        command_t c;
        c = '{cmd: op, index: 6'(idx), count: 7'(cnt), x: 8'(px), y: 8'(py),
              bits: 8'(fl), dir: 3'(dr)};
        return c;
    endfunction

    // Small boxes and clustered writes so the scan often hits early.
    function automatic command_t random_cmd(int lim);
        command_t c;
        int       sel;
        c     = '0;
        c.x   = 8'($urandom);
        c.y   = 8'($urandom);
        c.dir = 3'($urandom);
        c.bits = 8'($urandom);
        sel   = $urandom_range(0, 99);
        if (sel < 50)
        begin
            c.cmd   = CMD_WRITE;
            c.index = 6'($urandom_range(0, 15));
            if ($urandom_range(0, 3) == 0)
                c.index = 6'($urandom);
            if ($urandom_range(0, 1))
            begin
                c.x = 8'($urandom_range(100, 130));
                c.y = 8'($urandom_range(100, 130));
            end
        end
        else if (sel < 70)
        begin
            c.cmd   = CMD_DETECT;
            c.index = ($urandom_range(0, 5) == 0) ? 6'($urandom)
                                                  : 6'($urandom_range(0, 20));
        end
        else
        begin
            c.cmd   = (sel < 85) ? CMD_MOVE : CMD_REPACK;
            c.count = ($urandom_range(0, 7) == 0) ? 7'($urandom)
                                                  : 7'($urandom_range(0, lim));
        end
        c.count = c.count | (c.cmd == CMD_WRITE ? 7'($urandom) : 7'd0);
        return c;
    endfunction

    task automatic drain_and_settle();
        while (pending_cmds.size() != 0 || expected_replies.size() != 0)
            @(posedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_limit(logic [6:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        shadow_active = v;
    endtask

    // Driver: present the head of the queue; advance on each transfer.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_ready_q)
                ;
            else if (pending_cmds.size() != 0
                     && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid    <= 1'b1;
                cmd         <= pending_cmds[0].cmd;
                index       <= pending_cmds[0].index;
                count       <= pending_cmds[0].count;
                sprite_x    <= pending_cmds[0].x;
                sprite_y    <= pending_cmds[0].y;
                sprite_bits <= pending_cmds[0].bits;
                direction   <= pending_cmds[0].dir;
            end
            else
                in_valid <= 1'b0;
            out_ready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        in_ready_q <= 1'b0;
        if (in_valid && in_ready)
        begin
            in_ready_q <= 1'b1;
            expected_replies.push_back(run_command(pending_cmds.pop_front()));
        end
    end

    // Monitor: compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        reply_t exp_r;
        if (out_valid && out_ready)
        begin
            if (expected_replies.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                exp_r = expected_replies.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status expected %0d actual %0d", exp_r.status, status);
                    errors++;
                end
                if (first_index !== exp_r.first)
                begin
                    $error("first_index expected %0d actual %0d", exp_r.first, first_index);
                    errors++;
                end
                if (second_index !== exp_r.second)
                begin
                    $error("second_index expected %0d actual %0d",
                           exp_r.second, second_index);
                    errors++;
                end
                if (packed_count !== exp_r.packed_cnt)
                begin
                    $error("packed_count expected %0d actual %0d",
                           exp_r.packed_cnt, packed_count);
                    errors++;
                end
            end
        end
    end

    // Long receiver hold-off, counted in its own process.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            recv_hold   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            recv_hold <= 1'b0;
    end

    // Time limit: the worst scan, times stalls, many times over.
    initial
    begin
        #(12 * 8000000);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int limits [5];
        limits = '{7'd64, 7'd0, 7'd1, 7'd127, 7'd12};
        errors        = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        out_ready     = 1'b0;
        cmd           = CMD_WRITE;
        index         = '0;
        count         = '0;
        sprite_x      = '0;
        sprite_y      = '0;
        sprite_bits   = '0;
        direction     = '0;
        recv_hold     = 1'b0;
        hold_cycles   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        shadow_active = 7'd64;
        foreach (shadow_table[i])
            shadow_table[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, every command, the move and repack range cases.
        send_idle_pct = 25;
        recv_idle_pct = 77;
        pending_cmds.push_back(make_cmd(CMD_DETECT, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_WRITE, 0, 127, 255, 255, 8'hFF, 7));
        pending_cmds.push_back(make_cmd(CMD_WRITE, 1, 0, 0, 0, 8'h0D, 0));
        pending_cmds.push_back(make_cmd(CMD_WRITE, 2, 0, 2, 3, 8'h0D, 1));
        pending_cmds.push_back(make_cmd(CMD_WRITE, 3, 0, 254, 254, 8'hFD, 5));
        pending_cmds.push_back(make_cmd(CMD_WRITE, 63, 64, 255, 0, 8'h31, 3));
        pending_cmds.push_back(make_cmd(CMD_WRITE, 4, 0, 10, 10, 8'h00, 2));
        pending_cmds.push_back(make_cmd(CMD_DETECT, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_DETECT, 2, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_DETECT, 63, 0, 0, 0, 0, 0));
        for (int d = 0; d < 8; d++)
        begin
            pending_cmds.push_back(make_cmd(CMD_WRITE, 5, 0, 0, 255, 8'h0C, d));
            pending_cmds.push_back(make_cmd(CMD_MOVE, 0, 6, 0, 0, 0, 0));
        end
        pending_cmds.push_back(make_cmd(CMD_MOVE, 0, 65, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_MOVE, 0, 64, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_REPACK, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_REPACK, 0, 127, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_REPACK, 0, 64, 0, 0, 0, 0));
        drain_and_settle();

        // Pressure: stall the output while further commands wait at the input.
        hold_cycles = 400;
        for (int k = 0; k < 8; k++)
            pending_cmds.push_back(random_cmd(64));
        drain_and_settle();

        // Random phases across limits and idle mixes.
        foreach (limits[p])
        begin
            write_limit(7'(limits[p]));
            if (p == 2)
            begin
                send_idle_pct = 77;
                recv_idle_pct = 25;
            end
            if (p == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int k = 0; k < 52; k++)
                pending_cmds.push_back(random_cmd(limits[p] > 64 ? 64 : limits[p]));
            drain_and_settle();
        end

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
